FILE: rtl/core/msel_pkg.sv
// msel_pkg: shared types and constants for the median select engine.
// Holds the sequencer state type, the rank datapath control struct and
// fixed port widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msel_pkg;

   // Fixed widths of the request and result ports.
   localparam int REQ_SAMPLE_W = 32;
   localparam int MEDIAN_W     = 34;
   localparam int COUNT_W      = 7;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,    // taking samples into the store
      ST_CAND,    // read the candidate entry
      ST_LATCH,   // capture candidate, start the scan
      ST_SCAN,    // compare one stored sample per cycle against the candidate
      ST_EVAL,    // check whether the candidate covers a middle rank
      ST_EMIT     // hand the result to the output register
   } sel_state_type;

   // Sequencer to rank datapath.
   typedef struct packed {
      logic start;      // new set closed: clear found flags
      logic load_cand;  // read data is the candidate: capture it, clear counts
      logic cmp_en;     // read data is a scanned sample: update counts
      logic eval_en;    // counts complete for this candidate
   } rank_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/msel_store.sv
// msel_store: sample memory, one write port and one read port.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msel_store #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/msel_ctrl.sv
// msel_ctrl: load/select sequencer with fill count, overflow flag and
// candidate/scan indices. Depends on msel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msel_ctrl import msel_pkg::*; #(
   parameter int MAX_ITEMS = 64,
   parameter int CNT_W     = 7,
   parameter int ADDR_W    = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_last,
   output      logic              req_stall,
   input  wire logic              out_free,
   input  wire logic              done_now,
   output      logic              wr_en,
   output      logic [ADDR_W-1:0] wr_addr,
   output      logic              rd_en,
   output      logic [ADDR_W-1:0] rd_addr,
   output      rank_ctl_type      rank_ctl,
   output      logic [CNT_W-1:0]  sel_count,
   output      logic              sel_dropped,
   output      logic              emit
);

   sel_state_type    state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             drop_ff, drop_in;
   logic [CNT_W-1:0] cand_idx_ff, cand_idx_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;

   logic accept;
   logic room;
   logic scan_more;

   assign accept    = req_valid && (state_ff == ST_LOAD);
   assign room      = fill_ff < CNT_W'(MAX_ITEMS);
   assign scan_more = scan_idx_ff < fill_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last) begin
               state_in = ST_CAND;
            end
         end
         ST_CAND:  state_in = ST_LATCH;
         ST_LATCH: state_in = ST_SCAN;
         ST_SCAN: begin
            if (!scan_more) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = done_now ? ST_EMIT : ST_CAND;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall = 1'b1;
      wr_en     = 1'b0;
      wr_addr   = fill_ff[ADDR_W-1:0];
      rd_en     = 1'b0;
      rd_addr   = cand_idx_ff[ADDR_W-1:0];
      rank_ctl  = '0;
      emit      = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_stall      = 1'b0;
            wr_en          = accept && room;
            rank_ctl.start = accept && req_last;
         end
         ST_CAND: begin
            rd_en = 1'b1;
         end
         ST_LATCH: begin
            rd_en              = 1'b1;
            rd_addr            = '0;
            rank_ctl.load_cand = 1'b1;
         end
         ST_SCAN: begin
            rd_en           = scan_more;
            rd_addr         = scan_idx_ff[ADDR_W-1:0];
            rank_ctl.cmp_en = 1'b1;
         end
         ST_EVAL: begin
            rank_ctl.eval_en = 1'b1;
         end
         ST_EMIT: begin
            emit = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Counters and flags
   always_comb begin
      fill_in     = fill_ff;
      drop_in     = drop_ff;
      cand_idx_in = cand_idx_ff;
      scan_idx_in = scan_idx_ff;
      if (accept) begin
         if (room) begin
            fill_in = fill_ff + CNT_W'(1);
         end else begin
            drop_in = 1'b1;
         end
         cand_idx_in = '0;
      end
      if (state_ff == ST_LATCH) begin
         scan_idx_in = CNT_W'(1);
      end
      if ((state_ff == ST_SCAN) && scan_more) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end
      if ((state_ff == ST_EVAL) && !done_now) begin
         cand_idx_in = cand_idx_ff + CNT_W'(1);
      end
      if (emit) begin
         fill_in = '0;
         drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         fill_ff     <= '0;
         drop_ff     <= 1'b0;
         cand_idx_ff <= '0;
         scan_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         drop_ff     <= drop_in;
         cand_idx_ff <= cand_idx_in;
         scan_idx_ff <= scan_idx_in;
      end
   end

   assign sel_count   = fill_ff;
   assign sel_dropped = drop_ff;

endmodule

`default_nettype wire

FILE: rtl/core/msel_rank.sv
// msel_rank: rank datapath. Counts stored samples below and equal to the
// candidate and captures the middle samples. Depends on msel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msel_rank import msel_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int CNT_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rank_ctl_type     ctl,
   input  wire logic             sgn,
   input  wire logic [WIDTH-1:0] rd_data,
   input  wire logic [CNT_W-1:0] count,
   output      logic             done_now,
   output      logic [WIDTH-1:0] hi_val,
   output      logic [WIDTH-1:0] lo_val
);

   logic [WIDTH-1:0] cand_ff, cand_in;
   logic [CNT_W-1:0] lt_ff, lt_in;
   logic [CNT_W-1:0] eq_ff, eq_in;
   logic [WIDTH-1:0] hi_ff, hi_in;
   logic [WIDTH-1:0] lo_ff, lo_in;
   logic             hi_found_ff, hi_found_in;
   logic             lo_found_ff, lo_found_in;

   logic [WIDTH-1:0] key_cand;
   logic [WIDTH-1:0] key_data;
   logic [CNT_W:0]   rank_end;
   logic [CNT_W-1:0] k_hi;
   logic [CNT_W-1:0] k_lo;
   logic             odd;
   logic             hi_hit;
   logic             lo_hit;

   // Flipping the sign bit turns a signed order into an unsigned one.
   assign key_cand = {cand_ff[WIDTH-1] ^ sgn, cand_ff[WIDTH-2:0]};
   assign key_data = {rd_data[WIDTH-1] ^ sgn, rd_data[WIDTH-2:0]};

   // Candidate occupies sorted positions lt .. lt+eq-1.
   assign rank_end = {1'b0, lt_ff} + {1'b0, eq_ff};
   assign k_hi     = count >> 1;
   assign k_lo     = k_hi - CNT_W'(1);
   assign odd      = count[0];
   assign hi_hit   = ctl.eval_en && (lt_ff <= k_hi) && ({1'b0, k_hi} < rank_end);
   assign lo_hit   = ctl.eval_en && !odd && (lt_ff <= k_lo) && ({1'b0, k_lo} < rank_end);
   assign done_now = (hi_found_ff || hi_hit) && (odd || lo_found_ff || lo_hit);

   always_comb begin
      cand_in     = cand_ff;
      lt_in       = lt_ff;
      eq_in       = eq_ff;
      hi_in       = hi_ff;
      lo_in       = lo_ff;
      hi_found_in = hi_found_ff;
      lo_found_in = lo_found_ff;
      if (ctl.start) begin
         hi_found_in = 1'b0;
         lo_found_in = 1'b0;
      end
      if (ctl.load_cand) begin
         cand_in = rd_data;
         lt_in   = '0;
         eq_in   = '0;
      end
      if (ctl.cmp_en) begin
         if (key_data < key_cand) begin
            lt_in = lt_ff + CNT_W'(1);
         end
         if (key_data == key_cand) begin
            eq_in = eq_ff + CNT_W'(1);
         end
      end
      if (hi_hit) begin
         hi_in       = cand_ff;
         hi_found_in = 1'b1;
      end
      if (lo_hit) begin
         lo_in       = cand_ff;
         lo_found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      lt_ff   <= lt_in;
      eq_ff   <= eq_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_found_ff <= 1'b0;
         lo_found_ff <= 1'b0;
      end else begin
         hi_found_ff <= hi_found_in;
         lo_found_ff <= lo_found_in;
      end
   end

   assign hi_val = hi_ff;
   assign lo_val = lo_ff;

endmodule

`default_nettype wire

FILE: rtl/core/median_select_engine.sv
// median_select_engine: block median of integer samples, top level.
// Instantiates msel_store, msel_ctrl and msel_rank; uses msel_pkg.
//
// Channel   Dir  Handshake              Payload
// req_      in   req_valid / req_stall  req_sample[31:0], req_last
// rsp_      out  rsp_valid / rsp_stall  rsp_twice_median[33:0] (signed),
//                                       rsp_sample_count[6:0], rsp_overflow
// csr_      in   csr_valid / csr_ready  csr_signed_compare (reset 1)
//
// Sequence: a sample that does not close a set is taken while loading. A
// closing request starts a rank selection with n kept samples: each
// candidate goes through candidate read, latch, n scan reads and evaluate,
// and up to n candidates are tried until both middle ranks are found. The
// single read port of the sample memory makes the scan one read at a time.
// Reset clears control state only; the memory is not cleared and only
// entries written in the current set are read. req_stall is high during
// selection; the result register lets the next set load while it waits.
`timescale 1ns / 1ps
`default_nettype none

module median_select_engine import msel_pkg::*; #(
   parameter int MAX_ITEMS    = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic [REQ_SAMPLE_W-1:0]    req_sample,
   input  wire logic                       req_last,
   // result channel
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic signed [MEDIAN_W-1:0] rsp_twice_median,
   output      logic [COUNT_W-1:0]         rsp_sample_count,
   output      logic                       rsp_overflow,
   // register write
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic                       csr_signed_compare
);

   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int IN_EXT_W  = (SAMPLE_WIDTH > REQ_SAMPLE_W) ? SAMPLE_WIDTH : REQ_SAMPLE_W;
   localparam int SUM_W     = SAMPLE_WIDTH + 2;
   localparam int EXT_W     = (SUM_W > MEDIAN_W) ? SUM_W : MEDIAN_W;
   localparam int CNT_EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // ---- configuration register ----
   logic signed_ff, signed_in;

   assign csr_ready = 1'b1;
   assign signed_in = (csr_valid && csr_ready) ? csr_signed_compare : signed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_ff <= 1'b1;
      end else begin
         signed_ff <= signed_in;
      end
   end

   // ---- sequencer ----
   logic                    out_free;
   logic                    done_now;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   rank_ctl_type            rank_ctl;
   logic [CNT_W-1:0]        sel_count;
   logic                    sel_dropped;
   logic                    emit;

   msel_ctrl #(
      .MAX_ITEMS (MAX_ITEMS),
      .CNT_W     (CNT_W),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last    (req_last),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .done_now    (done_now),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rank_ctl    (rank_ctl),
      .sel_count   (sel_count),
      .sel_dropped (sel_dropped),
      .emit        (emit)
   );

   // ---- sample memory ----
   // Only the low SAMPLE_WIDTH bits of a sample are kept.
   logic [IN_EXT_W-1:0]     sample_ext;
   logic [SAMPLE_WIDTH-1:0] wr_data;
   logic [SAMPLE_WIDTH-1:0] rd_data;

   assign sample_ext = IN_EXT_W'(req_sample);
   assign wr_data    = sample_ext[SAMPLE_WIDTH-1:0];

   msel_store #(
      .DEPTH  (MAX_ITEMS),
      .WIDTH  (SAMPLE_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---- rank datapath ----
   logic [SAMPLE_WIDTH-1:0] hi_val;
   logic [SAMPLE_WIDTH-1:0] lo_val;

   msel_rank #(
      .WIDTH (SAMPLE_WIDTH),
      .CNT_W (CNT_W)
   ) u_rank (
      .clock    (clock),
      .reset    (reset),
      .ctl      (rank_ctl),
      .sgn      (signed_ff),
      .rd_data  (rd_data),
      .count    (sel_count),
      .done_now (done_now),
      .hi_val   (hi_val),
      .lo_val   (lo_val)
   );

   // ---- median sum ----
   // Odd count: twice the middle sample. Even count: sum of both middles.
   // Sign extension follows the compare mode.
   logic [SAMPLE_WIDTH-1:0] lo_pick;
   logic [EXT_W-1:0]        hi_ext;
   logic [EXT_W-1:0]        lo_ext;
   logic [EXT_W-1:0]        sum_ext;
   logic [CNT_EXT_W-1:0]    count_ext;

   assign lo_pick   = sel_count[0] ? hi_val : lo_val;
   assign hi_ext    = {{(EXT_W - SAMPLE_WIDTH){signed_ff & hi_val[SAMPLE_WIDTH-1]}}, hi_val};
   assign lo_ext    = {{(EXT_W - SAMPLE_WIDTH){signed_ff & lo_pick[SAMPLE_WIDTH-1]}}, lo_pick};
   assign sum_ext   = hi_ext + lo_ext;
   assign count_ext = CNT_EXT_W'(sel_count);

   // ---- result register ----
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MEDIAN_W-1:0] rsp_median_ff, rsp_median_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_median_in = rsp_median_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_median_in = sum_ext[MEDIAN_W-1:0];
         rsp_count_in  = count_ext[COUNT_W-1:0];
         rsp_ovf_in    = sel_dropped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_twice_median = rsp_median_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // ---- checks ----
   // Fill count never passes capacity.
   assert property (@(posedge clock) disable iff (reset)
      sel_count <= CNT_W'(MAX_ITEMS))
      else $error("fill count above capacity");

   // A result always covers at least one kept sample.
   assert property (@(posedge clock) disable iff (reset)
      emit |-> (sel_count != '0))
      else $error("result with empty set");

   // Dropped samples only happen once the store is full.
   assert property (@(posedge clock) disable iff (reset)
      (emit && sel_dropped) |-> (sel_count == CNT_W'(MAX_ITEMS)))
      else $error("overflow flagged below capacity");

   // A result never loads over one that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !emit)
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// tb_top: self-checking testbench for median_select_engine.
// Sends sample sets as requests, predicts each median in a scoreboard class
// and checks every result field; depends on msel_pkg and the engine RTL.
`timescale 1ns / 1ps

// Holds the set being loaded and the medians still owed by the engine.
class median_scoreboard;
   typedef struct {
      logic [msel_pkg::MEDIAN_W-1:0] twice_median;
      logic [msel_pkg::COUNT_W-1:0]  sample_count;
      logic                          overflow;
   } median_result_type;

   int                capacity;
   bit [31:0]         kept[$];
   bit                dropped;
   bit                signed_mode;
   median_result_type owed_q[$];
   int                errors;

   function new(int cap);
      capacity    = cap;
      dropped     = 1'b0;
      signed_mode = 1'b1;   // register resets to signed compare
      errors      = 0;
   endfunction

   function void set_mode(bit m);
      signed_mode = m;
   endfunction

   function int pending();
      return owed_q.size();
   endfunction

   // Raw sample to 34-bit two's complement per the current compare mode.
   function logic signed [33:0] widen(bit [31:0] raw);
      return signed_mode ? {{2{raw[31]}}, raw} : {2'b00, raw};
   endfunction

   // Accepted request: store it, and on the closing one compute the median.
   function void note_request(bit [31:0] sample, bit last);
      median_result_type  r;
      bit [31:0]          keys[$];
      bit [31:0]          k;
      bit [31:0]          flip;
      logic signed [33:0] mid_hi;
      logic signed [33:0] mid_lo;
      int                 n;
      int                 j;
      if (kept.size() < capacity) kept.push_back(sample);
      else dropped = 1'b1;
      if (!last) return;
      // flipping the sign bit makes signed order match unsigned order
      flip = signed_mode ? 32'h8000_0000 : 32'h0;
      foreach (kept[i]) begin
         k = kept[i] ^ flip;
         j = keys.size();
         keys.push_back(k);
         while (j > 0 && keys[j-1] > k) begin
            keys[j] = keys[j-1];
            j--;
         end
         keys[j] = k;
      end
      n      = keys.size();
      mid_hi = widen(keys[n/2] ^ flip);
      mid_lo = (n % 2) ? mid_hi : widen(keys[n/2-1] ^ flip);
      r.twice_median = mid_hi + mid_lo;
      r.sample_count = n[6:0];
      r.overflow     = dropped;
      owed_q.push_back(r);
      kept.delete();
      dropped = 1'b0;
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 200) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task check_result(logic [33:0] tm, logic [6:0] cnt, logic ovf);
      median_result_type e;
      if (owed_q.size() == 0) begin
         report($sformatf("result with none owed: twice_median=%0d count=%0d",
                          $signed(tm), cnt));
         return;
      end
      e = owed_q.pop_front();
      if (tm !== e.twice_median)
         report($sformatf("twice_median got %0d want %0d",
                          $signed(tm), $signed(e.twice_median)));
      if (cnt !== e.sample_count)
         report($sformatf("sample_count got %0d want %0d", cnt, e.sample_count));
      if (ovf !== e.overflow)
         report($sformatf("overflow got %0b want %0b", ovf, e.overflow));
   endtask
endclass

module tb_top;
   import msel_pkg::*;

   localparam int MAX_ITEMS     = 64;
   localparam bit MODE_UNSIGNED = 1'b0;
   localparam bit MODE_SIGNED   = 1'b1;
   localparam int HOLD_CYCLES   = 600;  // long receiver hold-off, fills the engine
   localparam int SETTLE_CYCLES = 16;   // quiet time before a register write
   localparam int PHASE_ITEMS   = 80;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [REQ_SAMPLE_W-1:0]    req_sample = '0;
   logic                       req_last = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [MEDIAN_W-1:0] rsp_twice_median;
   logic [COUNT_W-1:0]         rsp_sample_count;
   logic                       rsp_overflow;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic                       csr_signed_compare = 1'b0;

   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   bit        hold_arm = 1'b0;   // set by stimulus at a rising edge, taken by receiver
   int        hold_left = 0;     // owned by the receiver process
   int        requests_sent = 0;
   bit [31:0] recent[$];         // recent samples, reused to force duplicates

   median_scoreboard sb = new(MAX_ITEMS);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   median_select_engine #(
      .MAX_ITEMS   (MAX_ITEMS),
      .SAMPLE_WIDTH(32)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_twice_median  (rsp_twice_median),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_overflow      (rsp_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_signed_compare(csr_signed_compare)
   );

   // Receiver: random stall, plus one long hold-off counted here when armed.
   always @(negedge clock) begin
      if (hold_arm) begin
         hold_arm  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Monitor: everything is sampled at the rising edge; inputs move on the
   // falling edge, so nothing here races the drivers.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_mode(csr_signed_compare);
         if (req_valid && !req_stall) sb.note_request(req_sample, req_last);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_twice_median, rsp_sample_count, rsp_overflow);
      end
   end

   // All drive tasks start and end in a falling-edge time step.
   task automatic send_sample(input bit [31:0] s, input bit l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= l;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_list(input bit [31:0] vals[$]);
      foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
   endtask

   // Mix of full-range bits, values near zero and near the sign boundary,
   // the extremes, and repeats of recent values.
   function automatic bit [31:0] random_sample();
      bit [31:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 16) - 8;
         2: v = (recent.size() != 0) ? recent[$urandom_range(0, recent.size() - 1)]
                                     : $urandom;
         3: case ($urandom_range(0, 3))
               0: v = 32'h0000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h8000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         default: v = 32'h8000_0000 + $urandom_range(0, 16) - 8;
      endcase
      recent.push_back(v);
      if (recent.size() > 16) void'(recent.pop_front());
      return v;
   endfunction

   // Mostly short sets so selection stays fast; now and then a near-full,
   // full or overflowing one.
   function automatic int random_set_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 24);
      return $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 4);
   endfunction

   task automatic send_set(input int len);
      for (int i = 0; i < len; i++) send_sample(random_sample(), i == len - 1);
   endtask

   // Sender pause: drop valid, wait until every owed median is out, then
   // let the engine settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input bit m);
      csr_valid          <= 1'b1;
      csr_signed_compare <= m;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input bit m,
                            input bit hold);
      int goal;
      wait_idle();
      write_mode(m);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      if (hold) begin
         @(posedge clock);
         hold_arm = 1'b1;
         @(negedge clock);
      end
      goal = requests_sent + PHASE_ITEMS;
      while (requests_sent < goal) send_set(random_set_len());
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // signed compare out of reset: single sample, extreme pairs,
      // odd and even sets across the sign boundary
      send_list('{32'h8000_0000});
      send_list('{32'h7FFF_FFFF, 32'h7FFF_FFFF});
      send_list('{32'h8000_0000, 32'h8000_0000});
      send_list('{32'd5, 32'hFFFF_FFFF, 32'd3});
      send_list('{32'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE});

      // unsigned compare: largest sum, zero, top bit as a big value
      wait_idle();
      write_mode(MODE_UNSIGNED);
      send_list('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_list('{32'h0000_0000});
      send_list('{32'd1, 32'hFFFF_FFFF, 32'h8000_0000});
      send_list('{32'h8000_0000, 32'h7FFF_FFFF});

      // store full: exactly full, closing request dropped, several dropped
      wait_idle();
      write_mode(MODE_SIGNED);
      send_set(MAX_ITEMS);
      send_set(MAX_ITEMS + 1);
      wait_idle();
      write_mode(MODE_UNSIGNED);
      send_set(MAX_ITEMS + 6);

      // random sets under three idle patterns; the first also holds the
      // receiver off long enough to back up the request side
      run_phase(11, 47, MODE_SIGNED, 1'b1);
      run_phase(47, 11, MODE_UNSIGNED, 1'b0);
      run_phase(0, 0, 1'($urandom_range(0, 1)), 1'b0);

      wait_idle();
      repeat (40) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/msel_pkg.sv
rtl/core/msel_store.sv
rtl/core/msel_ctrl.sv
rtl/core/msel_rank.sv
rtl/core/median_select_engine.sv
test/tb_top.sv
